// File: src/dqes_pkg.sv
// Shared types for the double-ended list with end search.
// Holds the command codes and the controller/datapath handshake structs.
// No dependencies.
package dqes_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT   = 2'd0,
    CMD_PUSH_BACK    = 2'd1,
    CMD_SEARCH_FRONT = 2'd2,
    CMD_SEARCH_BACK  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic push;
    logic scan_init;
    logic scan_run;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic search;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// File: src/dqes_ctrl.sv
// Controller state machine for the double-ended list with end search.
// Sequences accept, execute, scan and result hand-off; depends on dqes_pkg.
module dqes_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  dqes_pkg::sts_t  sts,
  output dqes_pkg::ctl_t  ctl,
  output logic            idle
);

  dqes_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      dqes_pkg::ST_IDLE: begin
        if (in_fire) begin
          ctl.load  = 1'b1;
          state_nxt = dqes_pkg::ST_EXEC;
        end
      end
      dqes_pkg::ST_EXEC: begin
        if (sts.search) begin
          ctl.scan_init = 1'b1;
          state_nxt     = dqes_pkg::ST_SCAN;
        end else begin
          ctl.push  = 1'b1;
          state_nxt = dqes_pkg::ST_DONE;
        end
      end
      dqes_pkg::ST_SCAN: begin
        ctl.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = dqes_pkg::ST_DONE;
        end
      end
      dqes_pkg::ST_DONE: begin
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = dqes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dqes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqes_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == dqes_pkg::ST_IDLE);

endmodule

// File: src/dqes_dp.sv
// Datapath for the double-ended list with end search.
// Holds the ring store, pointers, the scan pipeline and the result register; uses dqes_pkg.
module dqes_dp #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dqes_pkg::ctl_t  ctl,
  output dqes_pkg::sts_t  sts,
  input  logic [31:0]     in_tdata,
  input  logic [1:0]      in_tuser,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_data_r;
  logic [31:0]      key_r;
  dqes_pkg::cmd_t   cmd_r;
  logic [PTR_W-1:0] front_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] left_r;
  logic [PTR_W-1:0] iss_pos_r;
  logic [PTR_W-1:0] cmp_pos_r;
  logic             cmp_valid_r;
  logic             found_r;
  logic [PTR_W-1:0] pos_r;
  logic             ovf_r;
  logic             out_valid_r;
  logic             out_found_r;
  logic [3:0]       out_pos_r;
  logic             out_ovf_r;
  logic [4:0]       out_cnt_r;

  logic             full;
  logic             dir_back;
  logic             match;
  logic             issue;
  logic [PTR_W-1:0] front_nxt;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] back_addr;
  logic [PTR_W-1:0] wr_addr;
  logic             wr_en;

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                               input logic [PTR_W-1:0] pos);
    logic [PTR_W:0] s;
    s = {1'b0, front} + {1'b0, pos};
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign full      = (count_r == CNT_W'(DEPTH));
  assign dir_back  = (cmd_r == dqes_pkg::CMD_SEARCH_BACK);
  assign match     = cmp_valid_r && (rd_data_r == key_r) && !found_r;
  assign issue     = ctl.scan_run && (left_r != '0) && !found_r && !match;
  assign front_nxt = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - 1'b1;
  assign rd_addr   = slot_of(front_r, iss_pos_r);
  assign back_addr = slot_of(front_r, count_r[PTR_W-1:0]);
  assign wr_en     = ctl.push && !full;
  assign wr_addr   = (cmd_r == dqes_pkg::CMD_PUSH_FRONT) ? front_nxt : back_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= key_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        found_r <= 1'b0;
      end
      if (wr_en) begin
        count_r <= count_r + 1'b1;
        if (cmd_r == dqes_pkg::CMD_PUSH_FRONT) begin
          front_r <= front_nxt;
        end
      end
      if (ctl.scan_init) begin
        cmp_valid_r <= 1'b0;
      end else if (ctl.scan_run) begin
        cmp_valid_r <= issue;
      end
      if (match) begin
        found_r <= 1'b1;
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= in_tdata;
      cmd_r <= dqes_pkg::cmd_t'(in_tuser);
      pos_r <= '0;
      ovf_r <= 1'b0;
    end
    if (ctl.push) begin
      ovf_r <= full;
    end
    if (ctl.scan_init) begin
      left_r    <= count_r;
      iss_pos_r <= dir_back ? PTR_W'(count_r - 1'b1) : '0;
    end else if (issue) begin
      left_r    <= left_r - 1'b1;
      iss_pos_r <= dir_back ? iss_pos_r - 1'b1 : iss_pos_r + 1'b1;
      cmp_pos_r <= iss_pos_r;
    end
    if (match) begin
      pos_r <= cmp_pos_r;
    end
    if (ctl.emit) begin
      out_found_r <= found_r;
      out_pos_r   <= 4'(pos_r);
      out_ovf_r   <= ovf_r;
      out_cnt_r   <= 5'(count_r);
    end
  end

  assign sts.search    = (cmd_r == dqes_pkg::CMD_SEARCH_FRONT) || dir_back;
  assign sts.scan_done = found_r || ((left_r == '0) && !cmp_valid_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_ovf_r, out_pos_r, out_found_r};

endmodule

// File: src/deque_with_end_search.sv
// Top level of the double-ended list with end search.
// Joins dqes_ctrl and dqes_dp; depends on dqes_pkg.
//
// Usage: each input transaction carries a command in in_tuser and a signed
// 32-bit value in in_tdata. Commands push the value at the front or the back,
// or search for it from the front or the back. Every command yields exactly
// one output transaction with found, position, overflow and the entry count.
// Sequence: a push is written in the execute state and its result is then
// registered from the done state before the next transaction can be accepted.
// A search reads one stored entry per cycle from a single memory read port;
// each read entry is registered, then compared with the key, and the scan
// ends on a match or once every entry has been compared; an empty list is not
// read at all. A full store of DEPTH entries with no match is the worst case.
// One command is worked on at a time.
// After a result is registered, the next transaction is accepted while that
// result still waits for the receiver. If the receiver stalls, the finished
// command after it is held until the output register frees up.
// Reset empties the list; the store contents are not cleared.
// A push into a full list is dropped and reported with overflow set.
module deque_with_end_search #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] found, [4:1] position, [5] overflow, [10:6] entries
);

  dqes_pkg::ctl_t ctl;
  dqes_pkg::sts_t sts;
  logic           idle;

  assign in_tready = idle;

  dqes_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && in_tready),
    .sts     (sts),
    .ctl     (ctl),
    .idle    (idle)
  );

  dqes_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: src/dqes_checker.sv
// Port-level checker for the double-ended list with end search.
// Bound to deque_with_end_search; depends on nothing else.
module dqes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled output transaction changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted while a command was in progress.");

  a_found_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[5]))
    else $error("Result shows both found and overflow.");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind deque_with_end_search dqes_checker u_dqes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
